// ===== rtl/hde_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram distance engine package
// Shared types, codes and widths for the front queue, engine and result queue.
// ----------------------------------------------------------------------------
package hde_pkg;

  localparam int BinW   = 16;
  localparam int AccW   = 48;
  localparam int ResW   = 32;
  localparam int KindW  = 2;
  localparam int ModeW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_COS = 2'd0,
    MODE_CHI = 2'd1,
    MODE_EUC = 2'd2,
    MODE_ALL = 2'd3
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_CHI = 2'd0,
    KIND_COS = 2'd1,
    KIND_EUC = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SETUP, S_DIV, S_START, S_CHI1, S_CHI2, S_SQRT1,
    S_SQRT2, S_SQRT3, S_CMUL, S_CDIV0, S_CDIV, S_EMIT
  } state_e;

  typedef struct packed {
    logic [BinW-1:0] first_bin;
    logic [BinW-1:0] second_bin;
    logic            last_bin;
  } bin_item_t;

  typedef struct packed {
    logic [ResW-1:0] value;
    kind_e           kind;
    logic            err;
    logic            last;
  } result_t;

endpackage

// ===== rtl/hde_front.sv =====
// ----------------------------------------------------------------------------
// Front queue
// Two-entry input queue; takes bin words from the push side and holds them
// until the engine pulls them.
// ----------------------------------------------------------------------------
module hde_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hde_pkg::bin_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output hde_pkg::bin_item_t item_o,
  input  logic               pop_i
);
  import hde_pkg::*;

  bin_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/hde_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue of result words between the engine and the pop side.
// ----------------------------------------------------------------------------
module hde_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hde_pkg::result_t res_i,
  output logic             full_o,
  output logic             empty_o,
  output hde_pkg::result_t res_o,
  input  logic             pop_i
);
  import hde_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/hde_back.sv =====
// ----------------------------------------------------------------------------
// Distance engine
// Per bin: shared multiplier for the products, 2-bit-per-cycle divider for the
// chi-square term. On the last bin: metric sequencer with an iterative square
// root and a 1-bit-per-cycle divider for the cosine quotient.
// ----------------------------------------------------------------------------
module hde_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               item_valid_i,
  input  hde_pkg::bin_item_t item_i,
  output logic               item_pop_o,
  output logic               res_push_o,
  output hde_pkg::result_t   res_o,
  input  logic               res_full_i
);
  import hde_pkg::*;

  localparam logic [AccW-1:0] AccMax   = {AccW{1'b1}};
  localparam logic [13:0]     ChiScale = 14'd10000;

  function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] acc, logic [31:0] t);
    logic [AccW:0] s;
    s = {1'b0, acc} + {17'b0, t};
    return s[AccW] ? AccMax : s[AccW-1:0];
  endfunction

  state_e           state_q, state_d;
  mode_e            mode_q;
  kind_e            kind_q, kind_d;
  logic [15:0]      a_q, a_d, b_q, b_d;
  logic             last_q, last_d;
  logic [16:0]      den_q, den_d;
  logic [17:0]      crr_q, crr_d;      // chi remainder
  logic [31:0]      cnm_q, cnm_d;      // chi dividend bits still to shift in
  logic [31:0]      cqu_q, cqu_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [63:0]      prod_q;
  logic [31:0]      mul_a, mul_b;
  logic [AccW-1:0]  chi_q, chi_d, dot_q, dot_d, e1_q, e1_d, e2_q, e2_d, sqd_q, sqd_d;
  logic [61:0]      sv_q, sv_d;
  logic [30:0]      root_q, root_d, r1_q, r1_d;
  logic [35:0]      srem_q, srem_d;
  logic [61:0]      cd_q, cd_d;
  logic [63:0]      crem_q, crem_d;
  logic [30:0]      cnum_q, cnum_d, cquo_q, cquo_d;
  logic [37:0]      lo_q, lo_d;
  logic [31:0]      val_q, val_d;
  logic             err_q, err_d;

  // datapath helpers
  logic [15:0]      diff;
  logic [17:0]      dv_r;
  logic [31:0]      dv_n, dv_q;
  logic [35:0]      sq_rem2, sq_trial, sq_rem_n;
  logic [30:0]      sq_root_n;
  logic [63:0]      cd_r2;
  logic [30:0]      cd_qn;
  logic [63:0]      chi_total;
  logic [61:0]      cos_n;
  logic             last_res;

  assign diff = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);

  // chi divider: two quotient bits a cycle
  always_comb begin
    dv_r = crr_q;
    dv_n = cnm_q;
    dv_q = cqu_q;
    for (int i = 0; i < 2; i++) begin
      dv_r = {dv_r[16:0], dv_n[31]};
      dv_n = {dv_n[30:0], 1'b0};
      if (dv_r >= {1'b0, den_q}) begin
        dv_r = dv_r - {1'b0, den_q};
        dv_q = {dv_q[30:0], 1'b1};
      end else begin
        dv_q = {dv_q[30:0], 1'b0};
      end
    end
  end

  // square root: one result bit a cycle
  always_comb begin
    sq_rem2  = {srem_q[33:0], sv_q[61:60]};
    sq_trial = {3'b0, root_q, 2'b01};
    if (sq_rem2 >= sq_trial) begin
      sq_rem_n  = sq_rem2 - sq_trial;
      sq_root_n = {root_q[29:0], 1'b1};
    end else begin
      sq_rem_n  = sq_rem2;
      sq_root_n = {root_q[29:0], 1'b0};
    end
  end

  // cosine divider: one quotient bit a cycle
  always_comb begin
    cd_r2 = {crem_q[62:0], cnum_q[30]};
    if (cd_r2 >= {2'b0, cd_q}) begin
      cd_r2 = cd_r2 - {2'b0, cd_q};
      cd_qn = {cquo_q[29:0], 1'b1};
    end else begin
      cd_qn = {cquo_q[29:0], 1'b0};
    end
  end

  assign chi_total = {2'b0, prod_q[37:0], 24'b0} + {26'b0, lo_q} + 64'h0000_0000_8000_0000;
  assign cos_n     = {dot_q, 14'b0};
  assign last_res  = !(mode_q == MODE_ALL && kind_q != KIND_EUC);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LOAD: begin
        mul_a = {16'b0, diff};
        mul_b = {16'b0, diff};
      end
      S_SETUP: begin
        mul_a = {16'b0, a_q};
        mul_b = {16'b0, b_q};
      end
      S_DIV: begin
        mul_a = (cnt_q == 5'd16) ? {16'b0, a_q} : {16'b0, b_q};
        mul_b = (cnt_q == 5'd16) ? {16'b0, a_q} : {16'b0, b_q};
      end
      S_START: begin
        mul_a = {8'b0, chi_q[23:0]};
        mul_b = {18'b0, ChiScale};
      end
      S_CHI1: begin
        mul_a = {8'b0, chi_q[47:24]};
        mul_b = {18'b0, ChiScale};
      end
      S_CMUL: begin
        mul_a = {1'b0, r1_q};
        mul_b = {1'b0, root_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    a_d = a_q; b_d = b_q; last_d = last_q; den_d = den_q;
    crr_d = crr_q; cnm_d = cnm_q; cqu_d = cqu_q; cnt_d = cnt_q;
    chi_d = chi_q; dot_d = dot_q; e1_d = e1_q; e2_d = e2_q; sqd_d = sqd_q;
    sv_d = sv_q; root_d = root_q; r1_d = r1_q; srem_d = srem_q;
    cd_d = cd_q; crem_d = crem_q; cnum_d = cnum_q; cquo_d = cquo_q;
    lo_d = lo_q; val_d = val_q; err_d = err_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        item_pop_o = item_valid_i;
        if (item_valid_i) begin
          a_d     = item_i.first_bin;
          b_d     = item_i.second_bin;
          last_d  = item_i.last_bin;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        den_d   = {1'b0, a_q} + {1'b0, b_q};
        state_d = S_SETUP;
      end
      S_SETUP: begin
        sqd_d   = sat_add(sqd_q, prod_q[31:0]);
        crr_d   = {2'b0, prod_q[31:16]};
        cnm_d   = {prod_q[15:0], 16'b0};
        cqu_d   = '0;
        cnt_d   = 5'd16;
        state_d = S_DIV;
      end
      S_DIV: begin
        crr_d = dv_r;
        cnm_d = dv_n;
        cqu_d = dv_q;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd16) begin
          dot_d = sat_add(dot_q, prod_q[31:0]);
        end
        if (cnt_q == 5'd15) begin
          e1_d = sat_add(e1_q, prod_q[31:0]);
        end
        if (cnt_q == 5'd14) begin
          e2_d = sat_add(e2_q, prod_q[31:0]);
        end
        if (cnt_q == 5'd1) begin
          // both bins zero: term is zero
          chi_d = sat_add(chi_q, (den_q == 17'd0) ? 32'd0 : dv_q);
          if (last_q) begin
            case (mode_q)
              MODE_COS: kind_d = KIND_COS;
              MODE_EUC: kind_d = KIND_EUC;
              default:  kind_d = KIND_CHI;
            endcase
            state_d = S_START;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_START: begin
        err_d  = 1'b0;
        root_d = '0;
        srem_d = '0;
        cnt_d  = 5'd31;
        case (kind_q)
          KIND_CHI: state_d = S_CHI1;
          KIND_COS: begin
            if (e1_q == '0 || e2_q == '0) begin
              val_d   = '0;
              err_d   = 1'b1;
              state_d = S_EMIT;
            end else begin
              sv_d    = {e1_q, 14'b0};
              state_d = S_SQRT1;
            end
          end
          default: begin
            if (sqd_q[47:38] != '0) begin
              val_d   = 32'h7FFF_FFFF;
              state_d = S_EMIT;
            end else begin
              sv_d    = {sqd_q[37:0], 24'b0};
              state_d = S_SQRT3;
            end
          end
        endcase
      end
      S_CHI1: begin
        lo_d    = prod_q[37:0];
        state_d = S_CHI2;
      end
      S_CHI2: begin
        val_d   = chi_total[63:32];
        state_d = S_EMIT;
      end
      S_SQRT1, S_SQRT2, S_SQRT3: begin
        sv_d   = {sv_q[59:0], 2'b00};
        srem_d = sq_rem_n;
        root_d = sq_root_n;
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          if (state_q == S_SQRT1) begin
            r1_d    = sq_root_n;
            sv_d    = {e2_q, 14'b0};
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = 5'd31;
            state_d = S_SQRT2;
          end else if (state_q == S_SQRT2) begin
            state_d = S_CMUL;
          end else begin
            val_d   = {1'b0, sq_root_n};
            state_d = S_EMIT;
          end
        end
      end
      S_CMUL: state_d = S_CDIV0;
      S_CDIV0: begin
        // quotient of 8 or more saturates to -8.0
        if ({3'b0, cos_n} >= {prod_q[61:0], 3'b0}) begin
          val_d   = 32'h8000_0000;
          state_d = S_EMIT;
        end else begin
          cd_d    = prod_q[61:0];
          crem_d  = {5'b0, cos_n[61:3]};
          cnum_d  = {cos_n[2:0], 28'b0};
          cquo_d  = '0;
          cnt_d   = 5'd31;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        crem_d = cd_r2;
        cnum_d = {cnum_q[29:0], 1'b0};
        cquo_d = cd_qn;
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          val_d   = 32'd0 - {1'b0, cd_qn};
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          if (last_res) begin
            chi_d = '0; dot_d = '0; e1_d = '0; e2_d = '0; sqd_d = '0;
            state_d = S_IDLE;
          end else begin
            kind_d  = (kind_q == KIND_CHI) ? KIND_COS : KIND_EUC;
            state_d = S_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.value = val_q;
  assign res_o.kind  = kind_q;
  assign res_o.err   = err_q;
  assign res_o.last  = last_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_COS;
      cnt_q   <= '0;
      chi_q   <= '0;
      dot_q   <= '0;
      e1_q    <= '0;
      e2_q    <= '0;
      sqd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        mode_q <= mode_e'(cfg_data_i);
      end
      cnt_q <= cnt_d;
      chi_q <= chi_d;
      dot_q <= dot_d;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      sqd_q <= sqd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    a_q <= a_d; b_q <= b_d; last_q <= last_d; den_q <= den_d;
    crr_q <= crr_d; cnm_q <= cnm_d; cqu_q <= cqu_d;
    prod_q <= mul_a * mul_b;
    sv_q <= sv_d; root_q <= root_d; r1_q <= r1_d; srem_q <= srem_d;
    cd_q <= cd_d; crem_q <= crem_d; cnum_q <= cnum_d; cquo_q <= cquo_d;
    lo_q <= lo_d; val_q <= val_d; err_q <= err_d;
  end

  a_push_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> state_q == S_EMIT)
    else $error("result pushed outside emit");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_push_o && last_res) |=>
      (chi_q == '0 && dot_q == '0 && e1_q == '0 && e2_q == '0 && sqd_q == '0))
    else $error("accumulators not cleared after final result");

  a_err_cos_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.err) |-> (res_o.kind == KIND_COS && res_o.value == '0))
    else $error("divide error on a non-cosine result");

  a_cos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KIND_COS) |-> $signed(res_o.value) <= 0)
    else $error("negated cosine is positive");

endmodule

// ===== rtl/histogram_distance_engine_core.sv =====
// Per bin word: take, two setup states (load, setup), then 16 chi divider steps.
// A new bin word is taken only once the 2-bit-per-cycle chi divider is done.
// Last bin adds: chi-square two scaling multiplies, euclidean one 31-step square
//   root, cosine two 31-step square roots, a multiply and a 31-step divide.
// Reset: asynchronous, active low; clears queues, accumulators and mode (cosine).
// ----------------------------------------------------------------------------
// Histogram distance engine
// Front queue, distance engine and result queue; chi-square, negated cosine
// and euclidean metrics over streamed Q0.16 bin pairs.
// ----------------------------------------------------------------------------
module histogram_distance_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        first_bin_i,
  input  logic [15:0]        second_bin_i,
  input  logic               last_bin_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         metric_kind_o,
  output logic               divide_error_o,
  output logic               last_result_o
);
  import hde_pkg::*;

  bin_item_t in_item, eng_item;
  logic      eng_valid, eng_pop;
  result_t   eng_res, out_res;
  logic      res_push, res_full;

  assign cfg_ready_o = 1'b1;

  assign in_item.first_bin  = first_bin_i;
  assign in_item.second_bin = second_bin_i;
  assign in_item.last_bin   = last_bin_i;

  hde_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .valid_o (eng_valid),
    .item_o  (eng_item),
    .pop_i   (eng_pop)
  );

  hde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (eng_valid),
    .item_i       (eng_item),
    .item_pop_o   (eng_pop),
    .res_push_o   (res_push),
    .res_o        (eng_res),
    .res_full_i   (res_full)
  );

  hde_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (eng_res),
    .full_o  (res_full),
    .empty_o (empty),
    .res_o   (out_res),
    .pop_i   (pop)
  );

  assign result_value_o = $signed(out_res.value);
  assign metric_kind_o  = out_res.kind;
  assign divide_error_o = out_res.err;
  assign last_result_o  = out_res.last;

endmodule
